// ===== rtl/lpff_pkg.sv =====
// ----------------------------------------------------------------------------
// lpff_pkg: shared types and constants of the lidar point frame filter
// status codes, register indexes, cordic arctangent table and pipeline control
// ----------------------------------------------------------------------------
package lpff_pkg;

  // result status of one point
  typedef enum logic [1:0] {
    STATUS_KEPT  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_MASK  = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MAX_RANGE_SQ = 3'd0,
    REG_MOUNT_COS    = 3'd1,
    REG_MOUNT_SIN    = 3'd2,
    REG_OFFSET_X     = 3'd3,
    REG_OFFSET_Y     = 3'd4,
    REG_MASK_ENABLE  = 3'd5,
    REG_MASK_START   = 3'd6,
    REG_MASK_END     = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_WIDTH = 30;
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned TRIG_WIDTH = 16;   // q1.14 sine and cosine
  localparam int unsigned TRIG_FRAC = 14;
  localparam int unsigned MASK_WIDTH = 16;
  localparam int unsigned INTENSITY_WIDTH = 8;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CORDIC_PRESCALE = 16;
  localparam int unsigned PHASE_WIDTH = 32;  // 2^32 per turn inside the cordic

  localparam logic [29:0] RESET_MAX_RANGE_SQ = 30'd144000000;
  localparam logic signed [15:0] RESET_MOUNT_COS = 16'sd16384;
  localparam logic signed [15:0] RESET_MOUNT_SIN = 16'sd0;
  localparam logic [15:0] RESET_MASK_START = 16'd16384;
  localparam logic [15:0] RESET_MASK_END = 16'd40960;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // pipeline control handed to the cordic
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctrl_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_step(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lpff_cordic.sv =====
// ----------------------------------------------------------------------------
// lpff_cordic: pipelined vectoring cordic for the compass bearing
// one register stage per rotation step, side data travels with each point
// ----------------------------------------------------------------------------
module lpff_cordic
  import lpff_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int TAG_WIDTH = 41
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pipe_ctrl_t                    ctrl,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic [TAG_WIDTH-1:0]          tag_in,
  output logic                          res_valid,
  output logic [ANGLE_WIDTH-1:0]        res_bearing,
  output logic [TAG_WIDTH-1:0]          res_tag
);

  // prescaled vector plus cordic gain and diagonal growth
  localparam int VW = COORD_WIDTH + CORDIC_PRESCALE + 3;
  localparam logic [PHASE_WIDTH-1:0] ROUND_HALF =
    PHASE_WIDTH'(64'd1 << (PHASE_WIDTH - 1 - ANGLE_WIDTH));

  logic signed [VW-1:0]     u     [0:CORDIC_STEPS];
  logic signed [VW-1:0]     v     [0:CORDIC_STEPS];
  logic [PHASE_WIDTH-1:0]   phase [0:CORDIC_STEPS];
  logic                     vld   [0:CORDIC_STEPS];
  logic                     zero  [0:CORDIC_STEPS];
  logic [TAG_WIDTH-1:0]     tag   [0:CORDIC_STEPS];

  logic signed [VW-1:0] x_ext;
  logic signed [VW-1:0] y_ext;
  logic [PHASE_WIDTH-1:0] phase_rnd;

  assign x_ext = VW'(pos_x) <<< CORDIC_PRESCALE;
  assign y_ext = VW'(pos_y) <<< CORDIC_PRESCALE;

  // fold the lower half plane over
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ctrl.advance) begin
      vld[0] <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      zero[0] <= (pos_x == '0) && (pos_y == '0);
      tag[0]  <= tag_in;
      if (pos_y[COORD_WIDTH-1]) begin
        u[0]     <= -y_ext;
        v[0]     <= -x_ext;
        phase[0] <= HALF_TURN;
      end else begin
        u[0]     <= y_ext;
        v[0]     <= x_ext;
        phase[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ctrl.advance) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.advance) begin
        zero[i+1] <= zero[i];
        tag[i+1]  <= tag[i];
        if (!v[i][VW-1]) begin
          u[i+1]     <= u[i] + (v[i] >>> i);
          v[i+1]     <= v[i] - (u[i] >>> i);
          phase[i+1] <= phase[i] + atan_step(i);
        end else begin
          u[i+1]     <= u[i] - (v[i] >>> i);
          v[i+1]     <= v[i] + (u[i] >>> i);
          phase[i+1] <= phase[i] - atan_step(i);
        end
      end
    end
  end

  assign phase_rnd = phase[CORDIC_STEPS] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.advance) begin
      res_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      res_tag     <= tag[CORDIC_STEPS];
      res_bearing <= zero[CORDIC_STEPS] ? '0 : phase_rnd[PHASE_WIDTH-1 -: ANGLE_WIDTH];
    end
  end

endmodule

// ===== rtl/lidar_point_frame_filter.sv =====
// ----------------------------------------------------------------------------
// lidar_point_frame_filter: range gate, mount transform and bearing mask
// turns sensor-frame lidar points into robot-frame points with a status
// ----------------------------------------------------------------------------
// One point is taken per clock cycle while in_stall is low, and every point
// yields exactly one result transaction. The pipeline is three stages of
// range gate and mount transform (multipliers, rounded sums, offset with
// saturation), one fold stage, one stage per cordic rotation step (24), one
// bearing rounding stage and the output register with the mask test. The whole
// pipeline moves as one: while a finished result waits under out_stall, every
// stage holds and in_stall is raised, so nothing is lost or repeated.
// Configuration is plain write, one register per cfg_write cycle, and is
// expected to change only while no point is in flight.
module lidar_point_frame_filter
  import lpff_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]       cfg_data,
  // point channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   point_x,
  input  logic signed [COORD_WIDTH-1:0]   point_y,
  input  logic [INTENSITY_WIDTH-1:0]      point_intensity,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic signed [COORD_WIDTH-1:0]   robot_x,
  output logic signed [COORD_WIDTH-1:0]   robot_y,
  output logic [ANGLE_WIDTH-1:0]          bearing,
  output logic [INTENSITY_WIDTH-1:0]      out_intensity
);

  localparam int PW = COORD_WIDTH + TRIG_WIDTH;      // product width
  localparam int SW = PW + 1;                        // rotated sum width
  localparam int RW = SW - TRIG_FRAC;                // rounded rotation width
  localparam int OW = RW + 1;                        // with offset added
  localparam int DW = (2 * COORD_WIDTH + 1 > CFG_DATA_WIDTH) ?
                      2 * COORD_WIDTH + 1 : CFG_DATA_WIDTH;
  localparam int TAG_WIDTH = 2 * COORD_WIDTH + INTENSITY_WIDTH + 1;
  localparam logic signed [SW-1:0] ROUND_ROT = SW'(64'd1 << (TRIG_FRAC - 1));
  localparam logic signed [OW-1:0] SAT_HI = OW'((64'd1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_WIDTH) - 1);

  // configuration registers
  logic [29:0]                   max_range_sq;
  logic signed [TRIG_WIDTH-1:0]  mount_cos;
  logic signed [TRIG_WIDTH-1:0]  mount_sin;
  logic signed [COORD_WIDTH-1:0] offset_x;
  logic signed [COORD_WIDTH-1:0] offset_y;
  logic                          mask_enable;
  logic [MASK_WIDTH-1:0]         mask_start;
  logic [MASK_WIDTH-1:0]         mask_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range_sq <= RESET_MAX_RANGE_SQ;
      mount_cos    <= RESET_MOUNT_COS;
      mount_sin    <= RESET_MOUNT_SIN;
      offset_x     <= '0;
      offset_y     <= '0;
      mask_enable  <= 1'b1;
      mask_start   <= RESET_MASK_START;
      mask_end     <= RESET_MASK_END;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_RANGE_SQ: max_range_sq <= cfg_data[29:0];
        REG_MOUNT_COS:    mount_cos    <= cfg_data[TRIG_WIDTH-1:0];
        REG_MOUNT_SIN:    mount_sin    <= cfg_data[TRIG_WIDTH-1:0];
        REG_OFFSET_X:     offset_x     <= cfg_data[COORD_WIDTH-1:0];
        REG_OFFSET_Y:     offset_y     <= cfg_data[COORD_WIDTH-1:0];
        REG_MASK_ENABLE:  mask_enable  <= cfg_data[0];
        REG_MASK_START:   mask_start   <= cfg_data[MASK_WIDTH-1:0];
        REG_MASK_END:     mask_end     <= cfg_data[MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a result is held at the output
  logic advance;
  assign in_stall = out_valid && out_stall;
  assign advance  = !in_stall;

  // stage 1: squares and rotation products
  logic                          s1_valid;
  logic [2*COORD_WIDTH-1:0]      s1_sq_x;
  logic [2*COORD_WIDTH-1:0]      s1_sq_y;
  logic signed [PW-1:0]          s1_cx;
  logic signed [PW-1:0]          s1_sy;
  logic signed [PW-1:0]          s1_cy;
  logic signed [PW-1:0]          s1_sx;
  logic [INTENSITY_WIDTH-1:0]    s1_int;

  // full width squares, never negative
  logic signed [2*COORD_WIDTH-1:0] sq_x;
  logic signed [2*COORD_WIDTH-1:0] sq_y;

  assign sq_x = point_x * point_x;
  assign sq_y = point_y * point_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sq_x <= $unsigned(sq_x);
      s1_sq_y <= $unsigned(sq_y);
      s1_cx   <= mount_cos * point_x;
      s1_sy   <= mount_sin * point_y;
      s1_cy   <= mount_cos * point_y;
      s1_sx   <= mount_sin * point_x;
      s1_int  <= point_intensity;
    end
  end

  // stage 2: range gate and rounded rotation
  logic [DW-1:0]        radius_sq;
  logic signed [SW-1:0] rot_x_sum;
  logic signed [SW-1:0] rot_y_sum;

  assign radius_sq = DW'(s1_sq_x) + DW'(s1_sq_y);
  assign rot_x_sum = SW'(s1_cx) + SW'(s1_sy) + ROUND_ROT;
  assign rot_y_sum = SW'(s1_cy) - SW'(s1_sx) + ROUND_ROT;

  logic                       s2_valid;
  logic                       s2_drop;
  logic signed [RW-1:0]       s2_rot_x;
  logic signed [RW-1:0]       s2_rot_y;
  logic [INTENSITY_WIDTH-1:0] s2_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_drop  <= radius_sq > DW'(max_range_sq);
      s2_rot_x <= RW'(rot_x_sum >>> TRIG_FRAC);
      s2_rot_y <= RW'(rot_y_sum >>> TRIG_FRAC);
      s2_int   <= s1_int;
    end
  end

  // stage 3: mount offset with saturation
  logic signed [OW-1:0] ofs_x_sum;
  logic signed [OW-1:0] ofs_y_sum;
  logic signed [COORD_WIDTH-1:0] sat_x;
  logic signed [COORD_WIDTH-1:0] sat_y;

  assign ofs_x_sum = OW'(s2_rot_x) + OW'(offset_x);
  assign ofs_y_sum = OW'(s2_rot_y) + OW'(offset_y);

  always_comb begin
    if (ofs_x_sum > SAT_HI) begin
      sat_x = COORD_WIDTH'(SAT_HI);
    end else if (ofs_x_sum < SAT_LO) begin
      sat_x = COORD_WIDTH'(SAT_LO);
    end else begin
      sat_x = COORD_WIDTH'(ofs_x_sum);
    end
    if (ofs_y_sum > SAT_HI) begin
      sat_y = COORD_WIDTH'(SAT_HI);
    end else if (ofs_y_sum < SAT_LO) begin
      sat_y = COORD_WIDTH'(SAT_LO);
    end else begin
      sat_y = COORD_WIDTH'(ofs_y_sum);
    end
  end

  logic                          s3_valid;
  logic                          s3_drop;
  logic signed [COORD_WIDTH-1:0] s3_x;
  logic signed [COORD_WIDTH-1:0] s3_y;
  logic [INTENSITY_WIDTH-1:0]    s3_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_drop <= s2_drop;
      s3_x    <= sat_x;
      s3_y    <= sat_y;
      s3_int  <= s2_int;
    end
  end

  // bearing through the cordic, point data rides along as a tag
  pipe_ctrl_t                 cordic_ctrl;
  logic                       c_valid;
  logic [ANGLE_WIDTH-1:0]     c_bearing;
  logic [TAG_WIDTH-1:0]       c_tag;
  logic                       c_drop;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic [INTENSITY_WIDTH-1:0] c_int;

  assign cordic_ctrl.advance = advance;
  assign cordic_ctrl.valid   = s3_valid;

  lpff_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_cordic (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (cordic_ctrl),
    .pos_x       (s3_x),
    .pos_y       (s3_y),
    .tag_in      ({s3_drop, s3_x, s3_y, s3_int}),
    .res_valid   (c_valid),
    .res_bearing (c_bearing),
    .res_tag     (c_tag)
  );

  assign {c_drop, c_x, c_y, c_int} = c_tag;

  // ignored arc test, the arc wraps past zero when start lies above end
  logic [31:0] arc_start;
  logic [31:0] arc_end;
  logic [31:0] bear_ext;
  logic        in_arc;
  status_t     status_next;

  assign arc_start = 32'(mask_start) & ANGLE_MASK;
  assign arc_end   = 32'(mask_end) & ANGLE_MASK;
  assign bear_ext  = 32'(c_bearing);

  always_comb begin
    if (arc_start <= arc_end) begin
      in_arc = (bear_ext >= arc_start) && (bear_ext <= arc_end);
    end else begin
      in_arc = (bear_ext >= arc_start) || (bear_ext <= arc_end);
    end
    if (c_drop) begin
      status_next = STATUS_RANGE;
    end else if (mask_enable && in_arc) begin
      status_next = STATUS_MASK;
    end else begin
      status_next = STATUS_KEPT;
    end
  end

  // output register, range-dropped points report a zero point and bearing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status        <= status_next;
      robot_x       <= c_drop ? '0 : c_x;
      robot_y       <= c_drop ? '0 : c_y;
      bearing       <= c_drop ? '0 : c_bearing;
      out_intensity <= c_int;
    end
  end

endmodule
